[sv/ats_pkg.sv]
package ats_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W = $clog2(SLOT_COUNT);

	localparam int CMD_W = 3;
	localparam int SLOT_IN_W = 6;
	localparam int TIME_W = 64;
	localparam int STATUS_W = 2;

	localparam int IN_BITS = CMD_W + SLOT_IN_W + TIME_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = STATUS_W + SLOT_IN_W + TIME_W;

	localparam logic [TIME_W-1:0] IDLE_MARK = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ASSIGN  = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_BEGIN   = 3'd2,
		CMD_END     = 3'd3,
		CMD_QUERY   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_ZERO_TS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ASSIGN,
		S_QUERY,
		S_QDRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_inc;
		logic rd_issue;
		logic full_set;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic slot_free;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

[sv/active_transaction_slot_table.sv]
// Active transaction slot table.
// Commands arrive as transactions on the s_ channel and each one produces
// exactly one result transaction on the m_ channel, in order.
// Assign searches the occupancy flags from slot 0 upwards, one slot per
// cycle, and takes the first free one; query reads the 64-bit entry memory
// one slot per cycle through its single read port and keeps a running
// minimum of the occupied entries.
// Release, begin and end go from decode straight to completion; assign
// scans until it finds a free slot or reaches the last one; query always
// scans every slot and then drains the last read before completion.
// One command is worked on at a time; the next is accepted once the result
// has moved to the output register, so a result may wait there while the
// next one is already being processed.
// When the receiver stalls, the result is held in the output register and
// the next command waits at completion until that result is taken.
// Reset marks every slot free at once; the entry memory itself needs no
// clearing, so the block is ready in the first cycle after reset.
module active_transaction_slot_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// command [2:0], slot [8:3], start_time [72:9], zero padding above
	input  logic [ats_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status [1:0], assigned_slot [7:2], oldest_time [71:8]
	output logic [ats_pkg::OUT_TDATA_W-1:0] m_tdata
);

	ats_pkg::dp_cmd_t  cmd;
	ats_pkg::dp_stat_t stat;

	ats_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ats_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

[sv/ats_ram.sv]
module ats_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/ats_ctrl.sv]
module ats_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  ats_pkg::dp_stat_t stat,
	output ats_pkg::dp_cmd_t  cmd
);

	ats_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ats_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ats_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = ats_pkg::S_DECODE;
				end
			end
			ats_pkg::S_DECODE: begin
				unique case (stat.cmd)
					ats_pkg::CMD_ASSIGN: state_d = ats_pkg::S_ASSIGN;
					ats_pkg::CMD_QUERY:  state_d = ats_pkg::S_QUERY;
					default:             state_d = ats_pkg::S_DONE;
				endcase
			end
			ats_pkg::S_ASSIGN: begin
				if (stat.slot_free || stat.scan_last) begin
					state_d = ats_pkg::S_DONE;
				end
			end
			ats_pkg::S_QUERY: begin
				if (stat.scan_last) begin
					state_d = ats_pkg::S_QDRAIN;
				end
			end
			ats_pkg::S_QDRAIN: state_d = ats_pkg::S_DONE;
			ats_pkg::S_DONE: begin
				if (stat.out_free) begin
					state_d = ats_pkg::S_IDLE;
				end
			end
			default: state_d = ats_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ats_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ats_pkg::S_ASSIGN: begin
				if (!stat.slot_free) begin
					if (stat.scan_last) begin
						cmd.full_set = 1'b1;
					end else begin
						cmd.scan_inc = 1'b1;
					end
				end
			end
			ats_pkg::S_QUERY: begin
				cmd.rd_issue = 1'b1;
				cmd.scan_inc = !stat.scan_last;
			end
			ats_pkg::S_DONE: begin
				cmd.finish = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

[sv/ats_dp.sv]
module ats_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ats_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ats_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  ats_pkg::dp_cmd_t               cmd,
	output ats_pkg::dp_stat_t              stat
);

	localparam int SW = ats_pkg::SLOT_W;
	localparam int TW = ats_pkg::TIME_W;

	ats_pkg::cmd_t                   cmd_q;
	logic [ats_pkg::SLOT_IN_W-1:0]   slot_q;
	logic [TW-1:0]                   time_q;
	logic [SW-1:0]                   scan_q;
	logic                            full_q;
	logic [ats_pkg::SLOT_COUNT-1:0]  valid_q;
	logic [TW-1:0]                   best_q;
	logic                            rd_pend_s1;
	logic [SW-1:0]                   rd_idx_s1;
	logic                            out_valid_q;
	logic [ats_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic          in_range;
	logic [SW-1:0] slot_idx;
	logic          we;
	logic [SW-1:0] waddr;
	logic [TW-1:0] wdata;
	logic [TW-1:0] rdata;
	logic          set_valid;
	logic          clr_valid;
	ats_pkg::status_t          res_status;
	logic [ats_pkg::SLOT_IN_W-1:0] res_slot;
	logic [TW-1:0]             res_time;

	assign in_range = 32'(slot_q) < ats_pkg::SLOT_COUNT;
	assign slot_idx = SW'(slot_q);

	ats_ram #(
		.WIDTH(TW),
		.DEPTH(ats_pkg::SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(scan_q),
		.rdata(rdata)
	);

	always_comb begin
		we = 1'b0;
		waddr = slot_idx;
		wdata = ats_pkg::IDLE_MARK;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		res_status = ats_pkg::ST_OK;
		res_slot = '0;
		res_time = '0;
		unique case (cmd_q)
			ats_pkg::CMD_ASSIGN: begin
				waddr = scan_q;
				if (full_q) begin
					res_status = ats_pkg::ST_FULL;
				end else begin
					we = 1'b1;
					set_valid = 1'b1;
					res_slot = ats_pkg::SLOT_IN_W'(scan_q);
				end
			end
			ats_pkg::CMD_RELEASE: begin
				clr_valid = in_range;
			end
			ats_pkg::CMD_BEGIN: begin
				wdata = time_q;
				if (time_q == '0) begin
					res_status = ats_pkg::ST_ZERO_TS;
				end else if (in_range) begin
					we = 1'b1;
					set_valid = 1'b1;
				end
			end
			ats_pkg::CMD_END: begin
				we = in_range;
				set_valid = in_range;
			end
			ats_pkg::CMD_QUERY: begin
				res_time = best_q;
			end
			default: ;
		endcase
		we = we && cmd.finish;
		set_valid = set_valid && cmd.finish;
		clr_valid = clr_valid && cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q <= s_tdata[ats_pkg::CMD_W +: ats_pkg::SLOT_IN_W];
			time_q <= s_tdata[ats_pkg::CMD_W + ats_pkg::SLOT_IN_W +: TW];
		end
		rd_idx_s1 <= scan_q;
		if (cmd.finish) begin
			out_data_q <= {res_time, res_slot, res_status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= ats_pkg::CMD_ASSIGN;
			scan_q <= '0;
			full_q <= 1'b0;
			valid_q <= '0;
			best_q <= '0;
			rd_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_issue;
			if (cmd.load) begin
				cmd_q <= ats_pkg::cmd_t'(s_tdata[ats_pkg::CMD_W-1:0]);
				scan_q <= '0;
				full_q <= 1'b0;
				best_q <= '0;
			end else begin
				if (cmd.scan_inc) begin
					scan_q <= scan_q + 1'b1;
				end
				if (cmd.full_set) begin
					full_q <= 1'b1;
				end
				if (rd_pend_s1 && valid_q[rd_idx_s1] && (best_q == '0 || rdata < best_q)) begin
					best_q <= rdata;
				end
			end
			if (set_valid) begin
				valid_q[waddr] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[slot_idx] <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign stat.cmd = cmd_q;
	assign stat.slot_free = !valid_q[scan_q];
	assign stat.scan_last = scan_q == SW'(ats_pkg::SLOT_COUNT - 1);
	assign stat.out_free = !out_valid_q || m_tready;

	a_assign_marks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && cmd_q == ats_pkg::CMD_ASSIGN && !full_q |=> valid_q[$past(scan_q)])
		else $error("assigned slot not marked as occupied");

	a_full_only_when_all_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && cmd_q == ats_pkg::CMD_ASSIGN && full_q |-> &valid_q)
		else $error("table reported full while a slot is free");

	a_empty_query_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && cmd_q == ats_pkg::CMD_QUERY && valid_q == '0 |-> best_q == '0)
		else $error("query on an empty table gave a non-zero time");

	a_scan_no_writes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue || rd_pend_s1 |-> !we)
		else $error("table written during a query scan");

endmodule
